/* hw/rtl/percentile_group_classifier_macros.svh */
// Assertion helpers shared by the classifier RTL.
`ifndef PERCENTILE_GROUP_CLASSIFIER_MACROS_SVH
`define PERCENTILE_GROUP_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PGC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PGC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/pgc_pkg.sv */
package pgc_pkg;

  localparam int unsigned DEF_MAX_VALUES = 256;
  localparam int unsigned DEF_MAX_GROUPS = 8;
  localparam int unsigned DEF_VALUE_BITS = 32;

  localparam int unsigned NUM_BOUNDS  = 8;
  localparam int unsigned BOUND_BITS  = 7;
  localparam int unsigned BOUNDS_BITS = NUM_BOUNDS * BOUND_BITS;
  localparam int unsigned GCNT_BITS   = 4;
  localparam int unsigned GIDX_BITS   = 4;

  localparam logic [BOUND_BITS-1:0] PCT_FULL = 7'd100;
  localparam logic [BOUND_BITS-1:0] PCT_HALF = 7'd50;

  // floor(x/100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x below 2^30
  localparam int unsigned RECIP_BITS  = 26;
  localparam int unsigned RECIP_SHIFT = 32;
  localparam logic [RECIP_BITS-1:0] RECIP_100 = 26'd42949673;

  localparam logic [1:0] CMD_LOAD     = 2'd0;
  localparam logic [1:0] CMD_FINISH   = 2'd1;
  localparam logic [1:0] CMD_CLASSIFY = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_READY = 2'd3;

  localparam logic CFG_GROUP_COUNT  = 1'b0;
  localparam logic CFG_GROUP_BOUNDS = 1'b1;

  localparam logic [GCNT_BITS-1:0]   RST_GROUP_COUNT  = 4'd1;
  localparam logic [BOUNDS_BITS-1:0] RST_GROUP_BOUNDS = 56'd100;

  // hand-off from the sequencer to the rank unit
  typedef struct packed {
    logic             load;
    logic [BOUND_BITS-1:0] pct;
  } rank_req_t;

endpackage

/* hw/rtl/pgc_cell.sv */
module pgc_cell import pgc_pkg::*; #(
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                         clk_i,
  input  logic                         ins_i,
  input  logic                         rot_i,
  input  logic                         occ_i,
  input  logic signed [VALUE_BITS-1:0] v_i,
  input  logic signed [VALUE_BITS-1:0] prev_val_i,
  input  logic                         prev_gt_i,
  output logic signed [VALUE_BITS-1:0] val_o,
  output logic                         gt_o
);

  logic signed [VALUE_BITS-1:0] val_q;

  assign val_o = val_q;
  // stored value lies above the incoming one: it moves up one place
  assign gt_o  = occ_i && (v_i < val_q);

  always_ff @(posedge clk_i) begin
    if (rot_i) begin
      val_q <= prev_val_i;
    end else if (ins_i) begin
      if (prev_gt_i) begin
        val_q <= prev_val_i;
      end else if (!occ_i || gt_o) begin
        val_q <= v_i;
      end
    end
  end

endmodule

/* hw/rtl/pgc_rank.sv */
module pgc_rank import pgc_pkg::*; #(
  parameter int unsigned MAX_VALUES = DEF_MAX_VALUES,
  localparam int unsigned CW = $clog2(MAX_VALUES + 1),
  localparam int unsigned IW = $clog2(MAX_VALUES)
) (
  input  logic          clk_i,
  input  rank_req_t     req_i,
  input  logic [CW-1:0] n_i,
  output logic [IW-1:0] rank_o
);

  localparam int unsigned XW = CW + BOUND_BITS;
  localparam int unsigned PW = XW + RECIP_BITS;
  localparam int unsigned RW = PW - RECIP_SHIFT;

  logic [XW-1:0] x_q;
  logic [PW-1:0] prod;
  logic [RW-1:0] raw;
  logic [XW-1:0] raw_x;
  logic [XW-1:0] top_x;

  // first stage: n * pct + 50
  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      x_q <= XW'(n_i) * XW'(req_i.pct) + XW'(PCT_HALF);
    end
  end

  // second stage: divide by 100 through the reciprocal, clamp at n - 1
  assign prod  = PW'(x_q) * PW'(RECIP_100);
  assign raw   = prod[PW-1:RECIP_SHIFT];
  assign raw_x = XW'(raw);
  assign top_x = XW'(n_i) - XW'(1);
  assign rank_o = (raw_x > top_x) ? top_x[IW-1:0] : raw_x[IW-1:0];

endmodule

/* hw/rtl/percentile_group_classifier.sv */
// Channel  | Signals                                   | Handshake
// ---------+-------------------------------------------+--------------------------
// command  | cmd_i, value_i, value_valid_i             | start_i high, busy_o low
// result   | status_o, found_o, group_index_o,         | done_o, one cycle, no stall
//          | group_value_o                             |
// config   | cfg_idx_i, cfg_wdata_i                    | cfg_we_i high
//
// Load and classify may follow back to back; the result appears on the cycle after
// the item is taken. Finish on a non-empty store keeps busy_o high while the rank
// unit loads and then stores the rank of each of the T thresholds (up to MAX_GROUPS+1),
// then the cell ring rotates once fully so that every rank can be picked from its
// last cell. Its result appears on the cycle after that. Reset clears counts and
// the ready flag; the store and thresholds hold no reset. The receiver cannot stall.
module percentile_group_classifier import pgc_pkg::*; #(
  parameter int unsigned MAX_VALUES = DEF_MAX_VALUES,
  parameter int unsigned MAX_GROUPS = DEF_MAX_GROUPS,
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   cmd_i,
  input  logic signed [VALUE_BITS-1:0] value_i,
  input  logic                         value_valid_i,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic                         found_o,
  output logic [GIDX_BITS-1:0]         group_index_o,
  output logic signed [VALUE_BITS-1:0] group_value_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [BOUNDS_BITS-1:0]       cfg_wdata_i
);

`include "percentile_group_classifier_macros.svh"

  localparam int unsigned CW = $clog2(MAX_VALUES + 1);
  localparam int unsigned IW = $clog2(MAX_VALUES);
  localparam int unsigned NT = MAX_GROUPS + 1;
  localparam int unsigned KW = $clog2(NT);
  localparam int unsigned TW = $clog2(NT + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RANK = 2'd1;
  localparam logic [1:0] S_ROT  = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [GCNT_BITS-1:0]   gcnt_q;
  logic [BOUNDS_BITS-1:0] bounds_q;
  logic [CW-1:0]          count_q;
  logic                   ready_q;
  logic [TW-1:0]          tcnt_q;
  logic [KW-1:0]          k_q;
  logic                   ph_q;
  logic [IW-1:0]          t_q;
  logic [IW-1:0]          rank_q [NT];
  logic signed [VALUE_BITS-1:0] thr_q [NT];

  logic                   done_q;
  logic [1:0]             status_q;
  logic                   found_q;
  logic [GIDX_BITS-1:0]   gidx_q;
  logic signed [VALUE_BITS-1:0] gval_q;

  logic                   accept;
  logic                   do_ins;
  logic                   do_rot;
  logic [BOUND_BITS-1:0]  bound [NUM_BOUNDS];
  logic [GCNT_BITS-1:0]   geff;
  logic [BOUND_BITS-1:0]  last_pct;
  logic [TW-1:0]          tcnt_new;
  logic [BOUND_BITS-1:0]  cur_pct;
  rank_req_t              rreq;
  logic [IW-1:0]          rank_new;
  logic                   cls_found;
  logic [GIDX_BITS-1:0]   cls_idx;
  logic signed [VALUE_BITS-1:0] cls_val;

  logic signed [VALUE_BITS-1:0] cval [MAX_VALUES];
  logic                         cgt  [MAX_VALUES];

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;
  assign do_ins = accept && (cmd_i == CMD_LOAD) && value_valid_i &&
                  (count_q < CW'(MAX_VALUES));
  assign do_rot = (state_q == S_ROT);

  // unpack bounds, clamp the group count, count thresholds
  always_comb begin
    for (int j = 0; j < NUM_BOUNDS; j++) begin
      bound[j] = bounds_q[j*BOUND_BITS +: BOUND_BITS];
    end
    if (gcnt_q == '0) begin
      geff = GCNT_BITS'(1);
    end else if (gcnt_q > GCNT_BITS'(MAX_GROUPS)) begin
      geff = GCNT_BITS'(MAX_GROUPS);
    end else begin
      geff = gcnt_q;
    end
    last_pct = '0;
    for (int j = 0; j < NUM_BOUNDS; j++) begin
      if (GCNT_BITS'(j + 1) == geff) last_pct = bound[j];
    end
    tcnt_new = TW'(geff) + ((last_pct != PCT_FULL) ? TW'(1) : TW'(0));
    // bounds past the group count take the appended full percent
    cur_pct = PCT_FULL;
    for (int j = 0; j < NUM_BOUNDS; j++) begin
      if ((GCNT_BITS'(j) == GCNT_BITS'(k_q)) && (GCNT_BITS'(j) < geff)) begin
        cur_pct = bound[j];
      end
    end
  end

  assign rreq.load = (state_q == S_RANK) && !ph_q;
  assign rreq.pct  = cur_pct;

  pgc_rank #(
    .MAX_VALUES(MAX_VALUES)
  ) u_rank (
    .clk_i (clk_i),
    .req_i (rreq),
    .n_i   (count_q),
    .rank_o(rank_new)
  );

  // sorted row of cells; the last one closes the ring for rotation
  for (genvar i = 0; i < MAX_VALUES; i++) begin : g_cell
    localparam int unsigned P = (i == 0) ? MAX_VALUES - 1 : i - 1;
    pgc_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .ins_i     (do_ins),
      .rot_i     (do_rot),
      .occ_i     (CW'(i) < count_q),
      .v_i       (value_i),
      .prev_val_i(cval[P]),
      .prev_gt_i ((i == 0) ? 1'b0 : cgt[P]),
      .val_o     (cval[i]),
      .gt_o      (cgt[i])
    );
  end

  // first threshold strictly above the value; scan downward so the lowest wins
  always_comb begin
    cls_found = 1'b0;
    cls_idx   = '0;
    cls_val   = '0;
    for (int j = NT - 1; j >= 0; j--) begin
      if ((TW'(j) < tcnt_q) && (value_i < thr_q[j])) begin
        cls_found = 1'b1;
        cls_idx   = GIDX_BITS'(j);
        cls_val   = thr_q[j];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (cmd_i == CMD_FINISH) && (count_q != '0)) state_d = S_RANK;
      end
      S_RANK: begin
        if (ph_q && (TW'(k_q) == tcnt_q - TW'(1))) state_d = S_ROT;
      end
      S_ROT: begin
        if (t_q == '0) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      gcnt_q   <= RST_GROUP_COUNT;
      bounds_q <= RST_GROUP_BOUNDS;
      count_q  <= '0;
      ready_q  <= 1'b0;
      tcnt_q   <= '0;
      k_q      <= '0;
      ph_q     <= 1'b0;
      t_q      <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_GROUP_COUNT) begin
          gcnt_q <= cfg_wdata_i[GCNT_BITS-1:0];
        end else begin
          bounds_q <= cfg_wdata_i;
        end
      end
      if (do_ins) begin
        count_q <= count_q + CW'(1);
        ready_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            // finish holds its result back until the ring has turned
            done_q <= !((cmd_i == CMD_FINISH) && (count_q != '0));
            if (cmd_i == CMD_FINISH) begin
              tcnt_q <= tcnt_new;
              k_q    <= '0;
              ph_q   <= 1'b0;
            end
          end
        end
        S_RANK: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (TW'(k_q) == tcnt_q - TW'(1)) begin
              t_q <= IW'(MAX_VALUES - 1);
            end else begin
              k_q <= k_q + KW'(1);
            end
          end
        end
        S_ROT: begin
          t_q <= t_q - IW'(1);
          if (t_q == '0) begin
            ready_q <= 1'b1;
            done_q  <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload: ranks, thresholds and result fields
  always_ff @(posedge clk_i) begin
    if ((state_q == S_RANK) && ph_q) begin
      for (int j = 0; j < NT; j++) begin
        if (KW'(j) == k_q) rank_q[j] <= rank_new;
      end
    end
    if (do_rot) begin
      // last cell now holds the entry of rank t_q
      for (int j = 0; j < NT; j++) begin
        if (rank_q[j] == t_q) thr_q[j] <= cval[MAX_VALUES-1];
      end
    end
    if (accept || do_rot) begin
      status_q <= ST_OK;
      found_q  <= 1'b0;
      gidx_q   <= '0;
      gval_q   <= '0;
    end
    if (accept) begin
      case (cmd_i)
        CMD_LOAD: begin
          if (value_valid_i && !do_ins) status_q <= ST_FULL;
        end
        CMD_FINISH: begin
          if (count_q == '0) status_q <= ST_EMPTY;
        end
        CMD_CLASSIFY: begin
          if (!ready_q) begin
            status_q <= ST_NOT_READY;
          end else if (value_valid_i) begin
            found_q <= cls_found;
            gidx_q  <= cls_idx;
            gval_q  <= cls_val;
          end
        end
        default: ;
      endcase
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_o       = found_q;
  assign group_index_o = gidx_q;
  assign group_value_o = gval_q;

  `PGC_ASSERT_NOW(a_found_ok, done_o && found_o, status_o == ST_OK, "found with bad status")
  `PGC_ASSERT_NOW(a_count_max, 1'b1, count_q <= CW'(MAX_VALUES), "store count overflow")
  `PGC_ASSERT_NEXT(a_rot_end, do_rot && (t_q == '0), done_o && !busy_o && ready_q,
                   "finish did not complete")
  `PGC_ASSERT_NOW(a_idx_range, done_o && found_o, TW'(group_index_o) < tcnt_q,
                  "group index past threshold count")

endmodule
